@@ src/hbs_pkg.sv @@
// ----------------------------------------------------------------------------
// hbs_pkg: shared types and constants for the float format converter
// Mode codes, stage payload structs and format constants for fp16, bf16
// and fp32 element conversion.
// ----------------------------------------------------------------------------
package hbs_pkg;

  // Conversion mode codes; codes 6 and 7 are unused and give zero
  typedef enum logic [2:0] {
    FUNC_F32_F32   = 3'd0,
    FUNC_BF16_F32  = 3'd1,
    FUNC_F16_F32   = 3'd2,
    FUNC_BF16_BF16 = 3'd3,
    FUNC_F16_BF16  = 3'd4,
    FUNC_F32_BF16  = 3'd5
  } func_e;

  localparam int unsigned FuncW  = 3;
  localparam int unsigned WordW  = 32;
  localparam int unsigned HalfW  = 16;
  localparam int unsigned F16ManW = 10;
  localparam int unsigned LzW    = 4;

  // Format constants
  localparam logic [WordW-1:0] BF16_RND_BIAS = 32'h0000_7fff;
  localparam logic [WordW-1:0] F32_EXP_INF   = 32'h7f80_0000;
  localparam logic [4:0]       F16_EXP_ONES  = 5'h1f;
  localparam logic [7:0]       F16_REBIAS    = 8'(127 - 15);
  localparam logic [7:0]       F16_SUB_BASE  = 8'(127 - 15 + 1);

  // Decode stage to widen stage
  typedef struct packed {
    func_e              func;
    logic [WordW-1:0]   value;
    logic [LzW-1:0]     lz;       // leading zeros of the fp16 mantissa
    logic               man_zero;
    logic               exp_zero;
    logic               exp_ones;
  } dec_t;

  // Widen stage to round stage
  typedef struct packed {
    logic               do_round;
    logic [WordW-1:0]   word;
  } wid_t;

endpackage

@@ src/hbs_decode.sv @@
// ----------------------------------------------------------------------------
// hbs_decode: first pipeline stage
// Registers the incoming element with the fp16 field classes and the
// leading-zero count of the fp16 mantissa.
// ----------------------------------------------------------------------------
module hbs_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [hbs_pkg::FuncW-1:0] func_i,
  input  logic [hbs_pkg::WordW-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output hbs_pkg::dec_t             out_o
);
  import hbs_pkg::*;

  logic                valid_q;
  dec_t                data_d, data_q;
  logic [F16ManW-1:0]  man;
  logic [LzW-1:0]      lz;

  assign man = value_i[F16ManW-1:0];

  // Count leading zeros of the 10-bit mantissa; the highest set bit wins
  always_comb begin
    lz = LzW'(F16ManW - 1);
    for (int i = 0; i < F16ManW; i++) begin
      if (man[i]) lz = LzW'(F16ManW - 1 - i);
    end
  end

  always_comb begin
    data_d.func     = func_e'(func_i);
    data_d.value    = value_i;
    data_d.lz       = lz;
    data_d.man_zero = (man == '0);
    data_d.exp_zero = (value_i[14:10] == 5'd0);
    data_d.exp_ones = (value_i[14:10] == F16_EXP_ONES);
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  // Advance the stage when it is empty or the next one can take the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

@@ src/hbs_widen.sv @@
// ----------------------------------------------------------------------------
// hbs_widen: second pipeline stage
// Widens fp16 and bf16 sources to fp32, normalizes fp16 subnormals and
// selects the word for each mode ahead of rounding.
// ----------------------------------------------------------------------------
module hbs_widen (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hbs_pkg::dec_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hbs_pkg::wid_t out_o
);
  import hbs_pkg::*;

  logic               valid_q;
  wid_t               data_d, data_q;
  logic               sign;
  logic [4:0]         ex;
  logic [F16ManW-1:0] man;
  logic [F16ManW-1:0] man_sh;
  logic [7:0]         ex_sub;
  logic [WordW-1:0]   f16_wide;

  assign sign = in_i.value[15];
  assign ex   = in_i.value[14:10];
  assign man  = in_i.value[F16ManW-1:0];

  // Shift the leading one out of a subnormal mantissa
  assign man_sh = F16ManW'({man, 1'b0} << in_i.lz);
  assign ex_sub = F16_SUB_BASE - 8'(in_i.lz) - 8'd1;

  // Build the fp32 image of the fp16 source
  always_comb begin
    priority if (in_i.exp_zero && in_i.man_zero) begin
      f16_wide = {sign, 31'd0};
    end else if (in_i.exp_zero) begin
      f16_wide = {sign, ex_sub, man_sh, 13'd0};
    end else if (in_i.exp_ones) begin
      f16_wide = {sign, 31'd0} | F32_EXP_INF | {9'd0, man, 13'd0};
    end else begin
      f16_wide = {sign, 8'(ex) + F16_REBIAS, man, 13'd0};
    end
  end

  // Select the pre-rounding word per mode
  always_comb begin
    data_d.do_round = 1'b0;
    unique case (in_i.func)
      FUNC_F32_F32:   data_d.word = in_i.value;
      FUNC_BF16_F32:  data_d.word = {in_i.value[HalfW-1:0], {HalfW{1'b0}}};
      FUNC_F16_F32:   data_d.word = f16_wide;
      FUNC_BF16_BF16: data_d.word = {{HalfW{1'b0}}, in_i.value[HalfW-1:0]};
      FUNC_F16_BF16: begin
        data_d.word     = f16_wide;
        data_d.do_round = 1'b1;
      end
      FUNC_F32_BF16: begin
        data_d.word     = in_i.value;
        data_d.do_round = 1'b1;
      end
      default:        data_d.word = '0;
    endcase
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  // Advance the stage when it is empty or the next one can take the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

@@ src/hbs_round.sv @@
// ----------------------------------------------------------------------------
// hbs_round: third pipeline stage and output register
// Rounds fp32 to bf16 with round-to-nearest-even by bias add, or passes
// the word through.
// ----------------------------------------------------------------------------
module hbs_round (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  hbs_pkg::wid_t             in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [hbs_pkg::WordW-1:0] out_o
);
  import hbs_pkg::*;

  logic             valid_q;
  logic [WordW-1:0] sum;
  logic [WordW-1:0] data_d, data_q;

  // Add bias plus kept LSB; the sum wraps modulo 2^32
  assign sum = in_i.word + BF16_RND_BIAS + WordW'(in_i.word[HalfW]);

  assign data_d = in_i.do_round ? {{HalfW{1'b0}}, sum[WordW-1:HalfW]} : in_i.word;

  assign in_ready_o  = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  // Hold the result while the consumer stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

@@ src/half_bfloat_single_converter_core.sv @@
// ----------------------------------------------------------------------------
// half_bfloat_single_converter_core: fp16 / bf16 / fp32 element converter
// Three-stage pipeline: decode, widen, round.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------
//   input   | in        | valid_i / stall_o  | func_i, value_in_i
//   output  | out       | valid_o / stall_i  | value_out_o
//
// An input transfer passes through the three register stages decode, widen
// and round in order; one element is taken every cycle while the output
// is not stalled.
// Reset clears the stage valid bits only; data registers are not reset.
// A stall on the output holds the result and backs up stage by stage, so
// stall_o rises only once all three stages are full.
// ----------------------------------------------------------------------------
module half_bfloat_single_converter_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [hbs_pkg::FuncW-1:0] func_i,
  input  logic [hbs_pkg::WordW-1:0] value_in_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [hbs_pkg::WordW-1:0] value_out_o
);
  import hbs_pkg::*;

  logic s1_ready, s2_ready, s3_ready;
  logic s1_valid, s2_valid;
  dec_t s1_data;
  wid_t s2_data;

  assign stall_o = !s1_ready;

  // Decode fp16 fields and count mantissa leading zeros
  hbs_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_i),
    .in_ready_o  (s1_ready),
    .func_i      (func_i),
    .value_i     (value_in_i),
    .out_valid_o (s1_valid),
    .out_ready_i (s2_ready),
    .out_o       (s1_data)
  );

  // Widen to fp32 and select per mode
  hbs_widen u_widen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s2_ready),
    .in_i        (s1_data),
    .out_valid_o (s2_valid),
    .out_ready_i (s3_ready),
    .out_o       (s2_data)
  );

  // Round to bf16 where the mode asks and register the result
  hbs_round u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s3_ready),
    .in_i        (s2_data),
    .out_valid_o (valid_o),
    .out_stall_i (stall_i),
    .out_o       (value_out_o)
  );

endmodule

@@ src/hbs_checker.sv @@
// ----------------------------------------------------------------------------
// hbs_checker: port-level assertions for the converter core
// Checks reset, hold under stall, drain, pass-through and bf16 results.
// ----------------------------------------------------------------------------
module hbs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      valid_i,
  input logic                      stall_o,
  input logic [hbs_pkg::FuncW-1:0] func_i,
  input logic [hbs_pkg::WordW-1:0] value_in_i,
  input logic                      valid_o,
  input logic                      stall_i,
  input logic [hbs_pkg::WordW-1:0] value_out_o
);
  import hbs_pkg::*;

  logic in_xfer;
  logic bf16_mode;

  assign in_xfer   = valid_i && !stall_o;
  assign bf16_mode = (func_i == FUNC_BF16_BF16) || (func_i == FUNC_F16_BF16) ||
                     (func_i == FUNC_F32_BF16);

  // No result while reset is held
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !valid_o)
    else $error("result valid during reset");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(value_out_o))
    else $error("stalled result changed");

  // Drain the pipeline once idle, unstalled cycles have flushed every stage
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!valid_i && !stall_i) ##1 (!valid_i && !stall_i) ##1 (!valid_i && !stall_i)
    |=> !valid_o)
    else $error("pipeline did not drain");

  // Pass fp32 through unchanged when the output does not stall
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && func_i == FUNC_F32_F32) ##1 !stall_i ##1 !stall_i
    |=> valid_o && value_out_o == $past(value_in_i, 3))
    else $error("fp32 pass-through mismatch");

  // Keep the upper half zero for bf16 results
  a_bf16_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && bf16_mode) ##1 !stall_i ##1 !stall_i
    |=> valid_o && value_out_o[31:16] == 16'd0)
    else $error("bf16 result upper half not zero");

endmodule

bind half_bfloat_single_converter_core hbs_checker u_hbs_checker (.*);

@@ tb/tb_half_bfloat_single_converter_core.sv @@
// ----------------------------------------------------------------------------
// tb_half_bfloat_single_converter_core: float format converter testbench
// Drives fp32 / bf16 / fp16 elements with every mode code through the
// valid/stall input channel and predicts each converted word in the bench.
// Results are compared in order against a queue of expected words. The run
// covers directed corner values, random traffic under several idle and
// stall mixes, and a long output hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_half_bfloat_single_converter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import hbs_pkg::*;

  // Unused mode codes; the block answers them with zero
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  // Format constants for the predictor
  localparam logic [4:0]  HALF_EXP_ONES  = 5'h1f;
  localparam logic [7:0]  SINGLE_EXP_ONES = 8'hff;
  localparam logic [7:0]  HALF_REBIAS    = 8'd112;
  localparam logic [7:0]  HALF_SUB_EXP   = 8'd113;
  localparam logic [31:0] BF16_BIAS      = 32'h0000_7fff;

  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned DRAIN_LIMIT  = 50000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct {
    logic [2:0]  func;
    logic [31:0] value_in;
    logic [31:0] value_out;
  } conversion_t;

  logic                clk_i;
  logic                rst_ni;
  logic                valid_i;
  logic                stall_o;
  logic [FuncW-1:0]    func_i;
  logic [WordW-1:0]    value_in_i;
  logic                valid_o;
  logic                stall_i;
  logic [WordW-1:0]    value_out_o;

  conversion_t pending_q[$];
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned holdoff_cycles;

  half_bfloat_single_converter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .func_i      (func_i),
    .value_in_i  (value_in_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .value_out_o (value_out_o)
  );

  // Clock: 20 ns period
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Widen an fp16 pattern to fp32, normalizing subnormals
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic        sign;
    logic [4:0]  expo;
    logic [10:0] frac;
    logic [7:0]  e32;
    sign = h[15];
    expo = h[14:10];
    frac = {1'b0, h[9:0]};
    if (expo == '0) begin
      if (frac == '0) return {sign, 31'b0};
      e32 = HALF_SUB_EXP;
      while (!frac[10]) begin
        frac = frac << 1;
        e32  = e32 - 8'd1;
      end
      return {sign, e32, frac[9:0], 13'b0};
    end
    if (expo == HALF_EXP_ONES) return {sign, SINGLE_EXP_ONES, frac[9:0], 13'b0};
    return {sign, 8'({3'b0, expo} + HALF_REBIAS), frac[9:0], 13'b0};
  endfunction

  // Round fp32 to bf16, nearest even, with the sum wrapping at 32 bits
  function automatic logic [31:0] round_bf16(input logic [31:0] u);
    logic [31:0] sum;
    sum = u + BF16_BIAS + {31'b0, u[16]};
    return {16'b0, sum[31:16]};
  endfunction

  function automatic logic [31:0] convert_word(input logic [2:0] f, input logic [31:0] v);
    case (f)
      FUNC_F32_F32:   return v;
      FUNC_BF16_F32:  return {v[15:0], 16'b0};
      FUNC_F16_F32:   return widen_half(v[15:0]);
      FUNC_BF16_BF16: return {16'b0, v[15:0]};
      FUNC_F16_BF16:  return round_bf16(widen_half(v[15:0]));
      FUNC_F32_BF16:  return round_bf16(v);
      default:        return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one element, hold it until the transfer, then queue its expectation
  task automatic send_item(input logic [2:0] f, input logic [31:0] v);
    conversion_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i    <= 1'b0;
      func_i     <= 3'($urandom_range(7));
      value_in_i <= $urandom;
      @(negedge clk_i);
    end
    valid_i    <= 1'b1;
    func_i     <= f;
    value_in_i <= v;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    entry.func      = f;
    entry.value_in  = v;
    entry.value_out = convert_word(f, v);
    pending_q.push_back(entry);
    @(negedge clk_i);
  endtask

  // Lower valid and wait until every expected result has come back
  task automatic wait_results_drained();
    int unsigned waited;
    waited = 0;
    valid_i <= 1'b0;
    while (pending_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    @(negedge clk_i);
  endtask

  // Random element, biased toward exponent and rounding corners
  task automatic send_random_item();
    logic [2:0]  f;
    logic [31:0] v;
    if ($urandom_range(19) == 0) f = $urandom_range(1) ? FUNC_SPARE_7 : FUNC_SPARE_6;
    else f = 3'($urandom_range(5));
    v = $urandom;
    case ($urandom_range(9))
      0: v[14:10] = 5'h00;
      1: v[14:10] = HALF_EXP_ONES;
      2: begin
        v[14:10] = 5'h00;
        v[9:0]   = 10'(1 << $urandom_range(9));
      end
      3: v[15:0]  = 16'h8000;
      4: v[15:0]  = 16'h7fff;
      5: v[30:23] = SINGLE_EXP_ONES;
      6: v[31:16] = 16'hffff;
      default: ;
    endcase
    send_item(f, v);
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Drive the output stall: a counted hold-off first, otherwise random
  initial begin
    stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_cycles != 0) begin
        stall_i <= 1'b1;
        holdoff_cycles--;
      end else begin
        stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    conversion_t entry;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR: unexpected result value_out=%08h", value_out_o);
      end else begin
        entry = pending_q.pop_front();
        if (value_out_o !== entry.value_out) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR: func=%0d value_in=%08h expected=%08h actual=%08h",
                     entry.func, entry.value_in, entry.value_out, value_out_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner values for every mode
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(FUNC_F32_F32,   32'h0000_0000);
    send_item(FUNC_F32_F32,   32'hffff_ffff);
    send_item(FUNC_BF16_F32,  32'hdead_ffff);
    send_item(FUNC_BF16_F32,  32'h0000_8001);
    send_item(FUNC_F16_F32,   32'hffff_0000);
    send_item(FUNC_F16_F32,   32'h0000_8000);
    send_item(FUNC_F16_F32,   32'h0000_0001);
    send_item(FUNC_F16_F32,   32'h0000_83ff);
    send_item(FUNC_F16_F32,   32'h0000_7c00);
    send_item(FUNC_F16_F32,   32'h0000_fe01);
    send_item(FUNC_F16_F32,   32'h0000_7bff);
    send_item(FUNC_BF16_BF16, 32'habcd_ffff);
    send_item(FUNC_F16_BF16,  32'h0000_7fff);
    send_item(FUNC_F16_BF16,  32'hffff_0401);
    send_item(FUNC_F16_BF16,  32'h0000_3c07);
    send_item(FUNC_F32_BF16,  32'hffff_8000);
    send_item(FUNC_F32_BF16,  32'h3f80_8000);
    send_item(FUNC_F32_BF16,  32'h3f81_8000);
    send_item(FUNC_F32_BF16,  32'h3f80_7fff);
    send_item(FUNC_F32_BF16,  32'h7fff_ffff);
    send_item(FUNC_F32_BF16,  32'h7f80_0000);
    send_item(FUNC_SPARE_6,   32'hffff_ffff);
    send_item(FUNC_SPARE_7,   32'h1234_5678);
    wait_results_drained();
  endtask

  // Random traffic under one idle and stall mix
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (RANDOM_ITEMS) send_random_item();
    wait_results_drained();
  endtask

  // Hold the output off long enough to fill the pipeline and stall the input
  task automatic test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    holdoff_cycles = 60;
    @(negedge clk_i);
    repeat (30) send_random_item();
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_cycles = 0;
    rst_ni         = 1'b0;
    valid_i        = 1'b0;
    func_i         = '0;
    value_in_i     = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_random_traffic(0, 0);
    test_random_traffic(88, 0);
    test_output_holdoff();
    test_random_traffic(0, 88);
    test_random_traffic(16, 16);

    // Let any late result show up before the verdict
    repeat (10) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      error_count++;
      $display("ERROR: %0d expected results never arrived", pending_q.size());
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("ERROR: timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
src/hbs_pkg.sv
src/hbs_decode.sv
src/hbs_widen.sv
src/hbs_round.sv
src/half_bfloat_single_converter_core.sv
src/hbs_checker.sv
tb/tb_half_bfloat_single_converter_core.sv
